### src/chsl_pkg.sv
// ----------------------------------------------------------------------------
// chsl_pkg: shared types and constants of the channel hop signal logger
// Request and result layouts, configuration layout, register map, resets.
// ----------------------------------------------------------------------------
package chsl_pkg;

  localparam int unsigned CHANNELS_DEF = 16;
  localparam int unsigned MASK_W       = 16;
  localparam int unsigned PADDR_W      = 5;
  localparam int unsigned PDATA_W      = 32;

  localparam logic [15:0]        MASK_RST     = 16'hFFFF;
  localparam logic signed [7:0]  THR_RST      = -8'sd75;
  localparam logic [15:0]        DWELL_RST    = 16'd1500;
  localparam logic [15:0]        COOLDOWN_RST = 16'd1500;
  localparam logic [15:0]        DEBOUNCE_RST = 16'd200;

  // Register index, taken from paddr[4:2]
  typedef enum logic [2:0] {
    REG_CHANNEL_MASK    = 3'd0,
    REG_LEVEL_THRESHOLD = 3'd1,
    REG_DWELL_MS        = 3'd2,
    REG_COOLDOWN_MS     = 3'd3,
    REG_DEBOUNCE_MS     = 3'd4
  } reg_idx_e;

  // Request kind
  localparam logic KIND_START  = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  typedef struct packed {
    logic [15:0]       channel_mask;
    logic signed [7:0] level_threshold;
    logic [15:0]       dwell_ms;
    logic [15:0]       cooldown_ms;
    logic [15:0]       debounce_ms;
  } cfg_t;

  typedef struct packed {
    logic              kind;
    logic [31:0]       now_ms;
    logic signed [7:0] level_dbm;
    logic              button_down;
  } req_t;

  typedef struct packed {
    logic              hit;
    logic [3:0]        hit_channel;
    logic signed [7:0] hit_level;
    logic [31:0]       hit_total;
    logic [3:0]        channel_now;
    logic              retune;
    logic              hopping;
    logic              none_selected;
  } res_t;

endpackage

### src/channel_hop_signal_logger.sv
// ----------------------------------------------------------------------------
// channel_hop_signal_logger: scan session control with per-channel hit log
// Pipeline: an accepted request is held in the processing stage (a_req_q),
//   then its result in the result register (out_res_q). Throughput: one
//   request per cycle, held only by a stalled full output; the per-channel
//   read-modify-write of the last-hit table sets the single processing stage.
// Reset: asynchronous, active low; the last-hit table is all zero at once
//   through per-channel valid bits, no clearing pass.
// ----------------------------------------------------------------------------
module channel_hop_signal_logger #(
  parameter int unsigned CHANNELS = chsl_pkg::CHANNELS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // request channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  chsl_pkg::req_t               in_req_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output chsl_pkg::res_t               out_res_o,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [chsl_pkg::PADDR_W-1:0] paddr,
  input  logic [chsl_pkg::PDATA_W-1:0] pwdata,
  output logic [chsl_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);

  localparam int unsigned TW = $clog2(CHANNELS);

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  chsl_pkg::cfg_t cfg;

  chsl_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Channels past the mask width never take part
  logic [CHANNELS-1:0] sel;
  for (genvar g = 0; g < CHANNELS; g++) begin : g_sel
    if (g < chsl_pkg::MASK_W) begin : g_in
      assign sel[g] = cfg.channel_mask[g];
    end else begin : g_out
      assign sel[g] = 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Session state
  // --------------------------------------------------------------------------
  logic [TW-1:0]       tuned_q,   tuned_d;
  logic                hop_q,     hop_d;
  logic                latch_q,   latch_d;
  logic [31:0]         tog_q,     tog_d;
  logic [31:0]         lhop_q,    lhop_d;
  logic [31:0]         cnt_q,     cnt_d;
  logic [CHANNELS-1:0] hv_q,      hv_d;     // last-hit entry written since start

  // Processing stage: request plus the table read issued at its acceptance
  logic                a_valid_q, a_valid_d;
  chsl_pkg::req_t      a_req_q;
  logic                byp_q,     byp_d;    // entry written as this read went out
  logic [31:0]         byp_time_q;
  logic                rd_hv_q,   rd_hv_d;

  logic                out_valid_q, out_valid_d;
  chsl_pkg::res_t      out_res_q,   out_res_d;

  logic                in_acc;
  logic                a_fire;
  logic [TW-1:0]       rd_addr;
  logic [31:0]         ram_rdata;
  logic                ram_we;

  assign a_fire     = a_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = a_valid_q && !a_fire;
  assign in_acc     = in_valid_i && !in_stall_o;

  // --------------------------------------------------------------------------
  // Channel selection for the request in the stage
  // --------------------------------------------------------------------------
  logic          any_sel;
  logic [TW-1:0] first_ch;
  logic [TW-1:0] next_ch;

  chsl_hop #(.CHANNELS(CHANNELS)) u_hop (
    .sel_i   (sel),
    .cur_i   (tuned_q),
    .any_o   (any_sel),
    .first_o (first_ch),
    .next_o  (next_ch)
  );

  // --------------------------------------------------------------------------
  // Evaluate the request in the stage
  // --------------------------------------------------------------------------
  logic        is_start;
  logic [31:0] now;
  logic [31:0] last_hit;
  logic        hit_c;
  logic        hop_go;
  logic        move;
  logic [TW-1:0] tuned_n;
  logic        hop_n;

  assign is_start = (a_req_q.kind == chsl_pkg::KIND_START);
  assign now      = a_req_q.now_ms;
  // Forwarded write wins; an entry unwritten since start reads as zero
  assign last_hit = byp_q ? byp_time_q : (rd_hv_q ? ram_rdata : 32'd0);

  always_comb begin
    hop_n   = hop_q;
    latch_d = latch_q;
    tog_d   = tog_q;
    if (is_start) begin
      hop_n   = 1'b1;
      latch_d = 1'b1;
    end else if (latch_q) begin
      // wait for release
      if (!a_req_q.button_down) begin
        latch_d = 1'b0;
      end
    end else if (a_req_q.button_down &&
                 ((now - tog_q) > {16'd0, cfg.debounce_ms})) begin
      hop_n   = !hop_q;
      tog_d   = now;
      latch_d = 1'b1;
    end
  end

  assign hit_c  = !is_start && any_sel &&
                  ($signed(a_req_q.level_dbm) > $signed(cfg.level_threshold)) &&
                  ((now - last_hit) >= {16'd0, cfg.cooldown_ms});
  assign hop_go = !is_start && any_sel && hop_n &&
                  ((now - lhop_q) >= {16'd0, cfg.dwell_ms});
  assign move   = hop_go && (next_ch != tuned_q);
  assign tuned_n = is_start ? first_ch : (move ? next_ch : tuned_q);

  always_comb begin
    tuned_d = tuned_q;
    hop_d   = hop_q;
    lhop_d  = lhop_q;
    cnt_d   = cnt_q;
    hv_d    = hv_q;
    if (a_fire) begin
      tuned_d = tuned_n;
      hop_d   = hop_n;
      if (is_start || hop_go) begin
        lhop_d = now;
      end
      if (is_start) begin
        cnt_d = 32'd0;
        hv_d  = '0;
      end else if (hit_c) begin
        cnt_d          = cnt_q + 32'd1;
        hv_d[tuned_q]  = 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Last-hit table: read at acceptance, written when the stage fires
  // --------------------------------------------------------------------------
  assign ram_we  = a_fire && hit_c;
  assign rd_addr = tuned_d;   // channel left by the request ahead, if any

  chsl_ram #(.WIDTH(32), .DEPTH(CHANNELS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tuned_q),
    .wdata_i (now),
    .re_i    (in_acc),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    a_valid_d = a_valid_q;
    byp_d     = byp_q;
    rd_hv_d   = rd_hv_q;
    if (in_acc) begin
      a_valid_d = 1'b1;
      byp_d     = ram_we && (tuned_q == rd_addr);
      rd_hv_d   = hv_d[rd_addr];
    end else if (a_fire) begin
      a_valid_d = 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  always_comb begin
    out_res_d.hit           = hit_c;
    out_res_d.hit_channel   = hit_c ? 4'(tuned_q) : 4'd0;
    out_res_d.hit_level     = hit_c ? a_req_q.level_dbm : 8'sd0;
    out_res_d.hit_total     = cnt_d;
    out_res_d.channel_now   = 4'(tuned_n);
    out_res_d.retune        = is_start || move;
    out_res_d.hopping       = hop_n;
    out_res_d.none_selected = !is_start && !any_sel;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (a_fire) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tuned_q     <= '0;
      hop_q       <= 1'b1;
      latch_q     <= 1'b1;
      tog_q       <= 32'd0;
      lhop_q      <= 32'd0;
      cnt_q       <= 32'd0;
      hv_q        <= '0;
      a_valid_q   <= 1'b0;
      byp_q       <= 1'b0;
      rd_hv_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      tuned_q     <= tuned_d;
      hop_q       <= hop_d;
      if (a_fire) begin
        latch_q   <= latch_d;
        tog_q     <= tog_d;
      end
      lhop_q      <= lhop_d;
      cnt_q       <= cnt_d;
      hv_q        <= hv_d;
      a_valid_q   <= a_valid_d;
      byp_q       <= byp_d;
      rd_hv_q     <= rd_hv_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload: hold unless loaded
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_req_q    <= in_req_i;
      byp_time_q <= now;
    end
    if (a_fire) begin
      out_res_q  <= out_res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

endmodule

### src/chsl_ram.sv
// ----------------------------------------------------------------------------
// chsl_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module chsl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/chsl_cfg.sv
// ----------------------------------------------------------------------------
// chsl_cfg: configuration register file behind the APB-style port
// Five registers at word addresses; writes beyond the map are dropped.
// ----------------------------------------------------------------------------
module chsl_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [chsl_pkg::PADDR_W-1:0]        paddr,
  input  logic [chsl_pkg::PDATA_W-1:0]        pwdata,
  output logic [chsl_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready,
  output chsl_pkg::cfg_t                      cfg_o
);

  chsl_pkg::cfg_t     cfg_q;
  chsl_pkg::reg_idx_e idx;
  logic               wr_en;

  assign idx    = chsl_pkg::reg_idx_e'(paddr[chsl_pkg::PADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.channel_mask    <= chsl_pkg::MASK_RST;
      cfg_q.level_threshold <= chsl_pkg::THR_RST;
      cfg_q.dwell_ms        <= chsl_pkg::DWELL_RST;
      cfg_q.cooldown_ms     <= chsl_pkg::COOLDOWN_RST;
      cfg_q.debounce_ms     <= chsl_pkg::DEBOUNCE_RST;
    end else if (wr_en) begin
      case (idx)
        chsl_pkg::REG_CHANNEL_MASK:    cfg_q.channel_mask    <= pwdata[15:0];
        chsl_pkg::REG_LEVEL_THRESHOLD: cfg_q.level_threshold <= $signed(pwdata[7:0]);
        chsl_pkg::REG_DWELL_MS:        cfg_q.dwell_ms        <= pwdata[15:0];
        chsl_pkg::REG_COOLDOWN_MS:     cfg_q.cooldown_ms     <= pwdata[15:0];
        chsl_pkg::REG_DEBOUNCE_MS:     cfg_q.debounce_ms     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      chsl_pkg::REG_CHANNEL_MASK:    prdata = {16'd0, cfg_q.channel_mask};
      chsl_pkg::REG_LEVEL_THRESHOLD: prdata = {{24{cfg_q.level_threshold[7]}},
                                               cfg_q.level_threshold};
      chsl_pkg::REG_DWELL_MS:        prdata = {16'd0, cfg_q.dwell_ms};
      chsl_pkg::REG_COOLDOWN_MS:     prdata = {16'd0, cfg_q.cooldown_ms};
      chsl_pkg::REG_DEBOUNCE_MS:     prdata = {16'd0, cfg_q.debounce_ms};
      default:                       prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

### src/chsl_hop.sv
// ----------------------------------------------------------------------------
// chsl_hop: channel selection logic
// Lowest selected channel, and next selected channel above the current one
// with wrap-around.
// ----------------------------------------------------------------------------
module chsl_hop #(
  parameter int unsigned CHANNELS = chsl_pkg::CHANNELS_DEF
) (
  input  logic [CHANNELS-1:0]         sel_i,
  input  logic [$clog2(CHANNELS)-1:0] cur_i,
  output logic                        any_o,
  output logic [$clog2(CHANNELS)-1:0] first_o,
  output logic [$clog2(CHANNELS)-1:0] next_o
);

  localparam int unsigned TW = $clog2(CHANNELS);

  function automatic logic [TW-1:0] lowest(input logic [CHANNELS-1:0] v);
    logic [TW-1:0] idx;
    idx = '0;
    for (int i = CHANNELS - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = TW'(i);
      end
    end
    return idx;
  endfunction

  logic [CHANNELS-1:0] above;
  logic [CHANNELS-1:0] sel_above;

  for (genvar g = 0; g < CHANNELS; g++) begin : g_above
    assign above[g] = (TW'(g) > cur_i);
  end

  assign sel_above = sel_i & above;
  assign any_o     = |sel_i;
  assign first_o   = lowest(sel_i);
  // Wrap to the lowest selected channel when none lies above
  assign next_o    = (|sel_above) ? lowest(sel_above) : lowest(sel_i);

endmodule

### src/chsl_checker.sv
// ----------------------------------------------------------------------------
// chsl_checker: port-level checks for the channel hop signal logger
// Result hold under stall, request-to-result timing, stall and result rules.
// ----------------------------------------------------------------------------
module chsl_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input chsl_pkg::res_t out_res_o
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_res_o))
    else $error("stalled result changed");

  // A result appears on an empty output only after an accepted request
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result without matching request");

  // An empty output never stalls requests
  a_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("request stalled with empty output");

  // A skipped sample carries no hit and no retune
  a_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.none_selected |-> !out_res_o.hit && !out_res_o.retune)
    else $error("skipped sample reported hit or retune");

endmodule

bind channel_hop_signal_logger chsl_checker u_chsl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_res_o   (out_res_o)
);
